[sv/ipg_pkg.sv]
// ----------------------------------------------------------------------------
// ipg_pkg
// Shared widths, register codes, reset values and types of the im2col patch
// gather core.
// ----------------------------------------------------------------------------
package ipg_pkg;

	localparam int WORD_W    = 32;   // raw pixel word
	localparam int ADDR_IN_W = 12;   // pixel_address field
	localparam int DIM_W     = 7;    // channels, height, width, out_row, out_col
	localparam int KSZ_W     = 4;    // kernel side and stride
	localparam int PAD_W     = 3;
	localparam int CH_W      = 6;
	localparam int RC_W      = 12;   // signed tap row / column
	localparam int GA_W      = 23;   // signed flat store address of a tap
	localparam int PADDR_W   = 5;
	localparam int REG_W     = 3;    // register index taken from paddr

	localparam int DEF_IMAGE_DEPTH = 4096;
	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_MAX_DIM     = 64;

	localparam int MAX_CHANNELS = 64;
	localparam int MAX_STRIDE   = 8;

	localparam logic [REG_W-1:0] REG_NUM_CHANNELS = 3'd0;
	localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [REG_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [REG_W-1:0] REG_KERNEL_SIZE  = 3'd3;
	localparam logic [REG_W-1:0] REG_STRIDE_STEP  = 3'd4;
	localparam logic [REG_W-1:0] REG_PAD_AMOUNT   = 3'd5;

	localparam logic [DIM_W-1:0] RST_NUM_CHANNELS = 7'd1;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 7'd8;
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 7'd8;
	localparam logic [KSZ_W-1:0] RST_KERNEL_SIZE  = 4'd3;
	localparam logic [KSZ_W-1:0] RST_STRIDE_STEP  = 4'd1;
	localparam logic [PAD_W-1:0] RST_PAD_AMOUNT   = 3'd1;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_GATHER = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] nc;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
		logic [KSZ_W-1:0] k;
		logic [KSZ_W-1:0] s;
		logic [PAD_W-1:0] p;
	} cfg_t;

	// one result slot handed from the sequencer to the output stage
	typedef struct packed {
		logic vld;
		logic rd;       // value comes from the store read
		logic padded;
		logic fault;
		logic last;
	} issue_t;

endpackage

[sv/ipg_ram.sv]
// ----------------------------------------------------------------------------
// ipg_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ipg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/ipg_seq.sv]
// ----------------------------------------------------------------------------
// ipg_seq
// Item sequencer: writes load words, runs the gather setup (products, range
// and overrun checks) and walks the kernel taps, one store read per in-image tap.
// ----------------------------------------------------------------------------
module ipg_seq import ipg_pkg::*; #(
	parameter int IMAGE_DEPTH = DEF_IMAGE_DEPTH,
	parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
	parameter int MAX_DIM     = DEF_MAX_DIM,
	localparam int AW         = $clog2(IMAGE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [ADDR_IN_W-1:0] pixel_address,
	input  logic [WORD_W-1:0]    pixel_value,
	input  logic [DIM_W-1:0]     out_row,
	input  logic [DIM_W-1:0]     out_col,
	input  logic [CH_W-1:0]      channel_sel,
	input  logic                 advance,
	output issue_t               issue,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [WORD_W-1:0]    mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_MUL2  = 3'd2;
	localparam logic [2:0] ST_MUL3  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_WALK  = 3'd5;
	localparam logic [2:0] ST_FAULT = 3'd6;

	logic [2:0] state_q;

	logic [DIM_W-1:0] orow_q, ocol_q;
	logic [CH_W-1:0]  ch_q;

	logic [10:0] rowprod_q, colprod_q;
	logic [12:0] chh_q;
	logic        cfg_ok_q;

	logic              bad_q, nonempty_q;
	logic [19:0]       base_q;
	logic signed [RC_W-1:0] r_lo_q, c_lo_q, rmax_q, cmax_q;

	logic signed [19:0] rlo_prod_q, rmax_prod_q;

	logic signed [GA_W-1:0] rowaddr_q;
	logic signed [RC_W-1:0] r_q, c_q;
	logic [KSZ_W-1:0]       kr_q, kc_q;

	logic accept, cfg_ok_d, load_ok;
	logic signed [RC_W-1:0] hm1, wm1, xr, xc;
	logic signed [RC_W-1:0] r_lo_d, r_hi_d, c_lo_d, c_hi_d;
	logic signed [GA_W-1:0] rowaddr_d, maxaddr_d, tap_addr;
	logic [KSZ_W-1:0] km1;
	logic in_img, last_tap, row_end, overrun;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_ok  = 32'(pixel_address) < IMAGE_DEPTH;

	assign mem_we    = accept && (kind == KIND_LOAD) && load_ok;
	assign mem_waddr = AW'(pixel_address);
	assign mem_wdata = pixel_value;

	always_comb begin
		cfg_ok_d = (cfg.nc != '0) && (32'(cfg.nc) <= MAX_CHANNELS)
			&& (cfg.h != '0) && (32'(cfg.h) <= MAX_DIM)
			&& (cfg.w != '0) && (32'(cfg.w) <= MAX_DIM)
			&& (cfg.k != '0) && (32'(cfg.k) <= MAX_KERNEL)
			&& (cfg.s != '0) && (32'(cfg.s) <= MAX_STRIDE)
			&& ({1'b0, cfg.h} + {4'b0, cfg.p, 1'b0} >= {4'b0, cfg.k})
			&& ({1'b0, cfg.w} + {4'b0, cfg.p, 1'b0} >= {4'b0, cfg.k});
	end

	// image bounds and the upper limit on the output position scaled by the stride
	assign hm1 = $signed(RC_W'(cfg.h)) - $signed(RC_W'(1));
	assign wm1 = $signed(RC_W'(cfg.w)) - $signed(RC_W'(1));
	assign xr  = $signed(RC_W'(cfg.h)) + $signed(RC_W'({cfg.p, 1'b0}))
		- $signed(RC_W'(cfg.k));
	assign xc  = $signed(RC_W'(cfg.w)) + $signed(RC_W'({cfg.p, 1'b0}))
		- $signed(RC_W'(cfg.k));

	assign r_lo_d = $signed(RC_W'(rowprod_q)) - $signed(RC_W'(cfg.p));
	assign c_lo_d = $signed(RC_W'(colprod_q)) - $signed(RC_W'(cfg.p));
	assign r_hi_d = r_lo_d + $signed(RC_W'(cfg.k)) - $signed(RC_W'(1));
	assign c_hi_d = c_lo_d + $signed(RC_W'(cfg.k)) - $signed(RC_W'(1));

	assign rowaddr_d = $signed({3'b0, base_q}) + rlo_prod_q;
	assign maxaddr_d = $signed({3'b0, base_q}) + rmax_prod_q + cmax_q;
	assign overrun   = nonempty_q && (maxaddr_d >= $signed(GA_W'(IMAGE_DEPTH)));

	assign km1      = cfg.k - 4'd1;
	assign row_end  = (kc_q == km1);
	assign last_tap = row_end && (kr_q == km1);
	assign in_img   = (r_q >= 0) && (r_q <= hm1) && (c_q >= 0) && (c_q <= wm1);
	assign tap_addr = rowaddr_q + c_q;
	assign mem_raddr = tap_addr[AW-1:0];

	always_comb begin
		issue = '0;
		case (state_q)
			ST_WALK: begin
				issue.vld    = 1'b1;
				issue.rd     = in_img;
				issue.padded = !in_img;
				issue.last   = last_tap;
			end
			ST_FAULT: begin
				issue.vld   = 1'b1;
				issue.fault = 1'b1;
				issue.last  = 1'b1;
			end
			default: ;
		endcase
	end

	assign mem_re = issue.vld && issue.rd && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_GATHER) state_q <= ST_MUL1;
						else if (!load_ok) state_q <= ST_FAULT;
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= (bad_q || overrun) ? ST_FAULT : ST_WALK;
				ST_WALK: begin
					if (advance && last_tap) state_q <= ST_IDLE;
				end
				ST_FAULT: begin
					if (advance) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			orow_q <= out_row;
			ocol_q <= out_col;
			ch_q   <= channel_sel;
		end
		if (state_q == ST_MUL1) begin
			cfg_ok_q  <= cfg_ok_d;
			rowprod_q <= 11'(orow_q * cfg.s);
			colprod_q <= 11'(ocol_q * cfg.s);
			chh_q     <= 13'(ch_q * cfg.h);
		end
		if (state_q == ST_MUL2) begin
			// orow >= (X / s) + 1 is the same as orow * s > X
			bad_q <= !cfg_ok_q
				|| ($signed(RC_W'(rowprod_q)) > xr)
				|| ($signed(RC_W'(colprod_q)) > xc)
				|| ({1'b0, ch_q} >= cfg.nc);
			nonempty_q <= (r_hi_d >= 0) && (r_lo_d <= hm1)
				&& (c_hi_d >= 0) && (c_lo_d <= wm1);
			base_q <= 20'(chh_q * cfg.w);
			r_lo_q <= r_lo_d;
			c_lo_q <= c_lo_d;
			rmax_q <= (r_hi_d < hm1) ? r_hi_d : hm1;
			cmax_q <= (c_hi_d < wm1) ? c_hi_d : wm1;
		end
		if (state_q == ST_MUL3) begin
			rlo_prod_q  <= r_lo_q * $signed({1'b0, cfg.w});
			rmax_prod_q <= rmax_q * $signed({1'b0, cfg.w});
		end
		if (state_q == ST_CHECK) begin
			rowaddr_q <= rowaddr_d;
			r_q       <= r_lo_q;
			c_q       <= c_lo_q;
			kr_q      <= '0;
			kc_q      <= '0;
		end
		if (state_q == ST_WALK && advance) begin
			if (row_end) begin
				kc_q      <= '0;
				c_q       <= c_lo_q;
				kr_q      <= kr_q + 4'd1;
				r_q       <= r_q + $signed(RC_W'(1));
				rowaddr_q <= rowaddr_q + $signed(GA_W'(cfg.w));
			end else begin
				kc_q <= kc_q + 4'd1;
				c_q  <= c_q + $signed(RC_W'(1));
			end
		end
	end

endmodule

[sv/ipg_ostage.sv]
// ----------------------------------------------------------------------------
// ipg_ostage
// Read stage that waits on the store read, then the output register that
// holds a result until its transfer.
// ----------------------------------------------------------------------------
module ipg_ostage import ipg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  issue_t            issue,
	output logic              advance,
	input  logic [WORD_W-1:0] rdata,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [WORD_W-1:0] value,
	output logic              padded,
	output logic              fault,
	output logic              last
);

	issue_t s1_q;
	logic   out_valid_q;
	logic   out_free;

	// rdata holds while the read stage stalls: no new read is issued then
	assign out_free = !out_valid_q || out_ready;
	assign advance  = !s1_q.vld || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) s1_q <= issue;
			if (out_free) out_valid_q <= s1_q.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_q.vld) begin
			value  <= s1_q.rd ? rdata : '0;
			padded <= s1_q.padded;
			fault  <= s1_q.fault;
			last   <= s1_q.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/im2col_patch_gather_core.sv]
// ----------------------------------------------------------------------------
// im2col_patch_gather_core
// Image store with im2col patch gather, configured over an APB-style port.
// ----------------------------------------------------------------------------
// Takes one item at a time. A load is written to the store on acceptance; one
// that overruns the store returns a fault instead. A gather first runs the setup
// states MUL1, MUL2, MUL3 and CHECK for the stride and address products and the
// range and overrun checks, then walks the kernel taps, one tap per cycle while
// the output stage advances, since the image store has a single read port.
// Results leave through an output register, so a stalled consumer holds the tap
// walk only once that register and the read stage are both full. The store has
// no reset; only entries written by loads may be gathered.
module im2col_patch_gather_core import ipg_pkg::*; #(
	parameter int IMAGE_DEPTH = DEF_IMAGE_DEPTH,
	parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [ADDR_IN_W-1:0] pixel_address,
	input  logic [WORD_W-1:0]    pixel_value,
	input  logic [DIM_W-1:0]     out_row,
	input  logic [DIM_W-1:0]     out_col,
	input  logic [CH_W-1:0]      channel_sel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_W-1:0]    value,
	output logic                 padded,
	output logic                 fault,
	output logic                 last
);

	localparam int AW = $clog2(IMAGE_DEPTH);

	cfg_t   cfg_q;
	issue_t issue;
	logic   advance;
	logic   mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	logic [REG_W-1:0]  reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nc <= RST_NUM_CHANNELS;
			cfg_q.h  <= RST_IMAGE_HEIGHT;
			cfg_q.w  <= RST_IMAGE_WIDTH;
			cfg_q.k  <= RST_KERNEL_SIZE;
			cfg_q.s  <= RST_STRIDE_STEP;
			cfg_q.p  <= RST_PAD_AMOUNT;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_CHANNELS: cfg_q.nc <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.h  <= pwdata[DIM_W-1:0];
				REG_IMAGE_WIDTH:  cfg_q.w  <= pwdata[DIM_W-1:0];
				REG_KERNEL_SIZE:  cfg_q.k  <= pwdata[KSZ_W-1:0];
				REG_STRIDE_STEP:  cfg_q.s  <= pwdata[KSZ_W-1:0];
				REG_PAD_AMOUNT:   cfg_q.p  <= pwdata[PAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_CHANNELS: prdata = 32'(cfg_q.nc);
			REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.h);
			REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.w);
			REG_KERNEL_SIZE:  prdata = 32'(cfg_q.k);
			REG_STRIDE_STEP:  prdata = 32'(cfg_q.s);
			REG_PAD_AMOUNT:   prdata = 32'(cfg_q.p);
			default:          prdata = '0;
		endcase
	end

	ipg_seq #(
		.IMAGE_DEPTH (IMAGE_DEPTH),
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_DIM     (MAX_DIM)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.channel_sel   (channel_sel),
		.advance       (advance),
		.issue         (issue),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr)
	);

	ipg_ram #(
		.WIDTH (WORD_W),
		.DEPTH (IMAGE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ipg_ostage u_ostage (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.advance   (advance),
		.rdata     (mem_rdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.value     (value),
		.padded    (padded),
		.fault     (fault),
		.last      (last)
	);

endmodule

[sv/ipg_checker.sv]
// ----------------------------------------------------------------------------
// ipg_checker
// Port-level checks of the im2col patch gather core, bound to the top level.
// ----------------------------------------------------------------------------
module ipg_checker import ipg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] value,
	input logic              padded,
	input logic              fault,
	input logic              last
);

	// a result waiting for its transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(padded)
			&& $stable(fault) && $stable(last))
		else $error("result changed while stalled");

	// a fault is a single closing result with no data
	a_fault_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> last && !padded && (value == '0))
		else $error("malformed fault result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && padded |-> (value == '0) && !fault)
		else $error("padding tap carries data");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind im2col_patch_gather_core ipg_checker u_ipg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.padded    (padded),
	.fault     (fault),
	.last      (last)
);

[tb/sv/im2col_patch_gather_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// im2col_patch_gather_core_tb
// Self-checking bench for the im2col patch gather core. Loads fill the image
// store and gathers stream out kernel patches. A predictor keeps its own copy of
// the store and of the geometry registers, and it queues the expected words
// for every gather and every faulting load. Each output transfer is checked
// against the oldest expected word. The run goes through several register
// settings, the extremes and invalid geometries among them, under varied
// source and sink throttling.
// ----------------------------------------------------------------------------
module im2col_patch_gather_core_tb import ipg_pkg::*;;

	localparam int NUM_PHASES    = 11;
	localparam int SETTLE_CYCLES = 80;    // longest patch walk plus margin
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;

	typedef struct {
		logic                 kind;
		logic [ADDR_IN_W-1:0] addr;
		logic [WORD_W-1:0]    word;
		logic [DIM_W-1:0]     row;
		logic [DIM_W-1:0]     col;
		logic [CH_W-1:0]      ch;
	} pixel_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              padded;
		logic              fault;
		logic              last;
	} tap_word_t;

	class patch_tracker;
		cfg_t              regs;
		logic [WORD_W-1:0] image [DEF_IMAGE_DEPTH];
		bit                loaded [DEF_IMAGE_DEPTH];
		int                tap_addr [$];   // store address per tap, -1 for padding
		tap_word_t         due [$];
		int                errors;

		function new();
			regs = '{nc: RST_NUM_CHANNELS, h: RST_IMAGE_HEIGHT, w: RST_IMAGE_WIDTH,
				k: RST_KERNEL_SIZE, s: RST_STRIDE_STEP, p: RST_PAD_AMOUNT};
			errors = 0;
		endfunction

		function void set_reg(logic [REG_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_NUM_CHANNELS: regs.nc = data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: regs.h = data[DIM_W-1:0];
				REG_IMAGE_WIDTH:  regs.w = data[DIM_W-1:0];
				REG_KERNEL_SIZE:  regs.k = data[KSZ_W-1:0];
				REG_STRIDE_STEP:  regs.s = data[KSZ_W-1:0];
				REG_PAD_AMOUNT:   regs.p = data[PAD_W-1:0];
				default: ;
			endcase
		endfunction

		function bit geometry_ok();
			return regs.nc >= 1 && regs.nc <= MAX_CHANNELS
				&& regs.h >= 1 && regs.h <= DEF_MAX_DIM
				&& regs.w >= 1 && regs.w <= DEF_MAX_DIM
				&& regs.k >= 1 && regs.k <= DEF_MAX_KERNEL
				&& regs.s >= 1 && regs.s <= MAX_STRIDE
				&& int'(regs.h) + 2 * int'(regs.p) >= int'(regs.k)
				&& int'(regs.w) + 2 * int'(regs.p) >= int'(regs.k);
		endfunction

		function int out_rows();
			return (int'(regs.h) + 2 * int'(regs.p) - int'(regs.k)) / int'(regs.s) + 1;
		endfunction

		function int out_cols();
			return (int'(regs.w) + 2 * int'(regs.p) - int'(regs.k)) / int'(regs.s) + 1;
		endfunction

		// Fills tap_addr in row-major kernel order; 0 when the gather faults.
		function bit walk_patch(int row, int col, int ch);
			int h, w, k, s, p, r, c, a;
			tap_addr.delete();
			if (!geometry_ok())
				return 0;
			if (row >= out_rows() || col >= out_cols() || ch >= int'(regs.nc))
				return 0;
			h = int'(regs.h);
			w = int'(regs.w);
			k = int'(regs.k);
			s = int'(regs.s);
			p = int'(regs.p);
			for (int kr = 0; kr < k; kr++) begin
				for (int kc = 0; kc < k; kc++) begin
					r = row * s + kr - p;
					c = col * s + kc - p;
					if (r >= 0 && c >= 0 && r < h && c < w) begin
						a = (ch * h + r) * w + c;
						if (a >= DEF_IMAGE_DEPTH) begin
							tap_addr.delete();
							return 0;
						end
						tap_addr.push_back(a);
					end else begin
						tap_addr.push_back(-1);
					end
				end
			end
			return 1;
		endfunction

		function void accept_item(pixel_op_t op);
			tap_word_t t;
			if (op.kind == KIND_LOAD && int'(op.addr) < DEF_IMAGE_DEPTH) begin
				image[op.addr] = op.word;
				loaded[op.addr] = 1'b1;
				return;
			end
			if (op.kind == KIND_LOAD || !walk_patch(op.row, op.col, op.ch)) begin
				due.push_back('{value: '0, padded: 1'b0, fault: 1'b1, last: 1'b1});
				return;
			end
			foreach (tap_addr[i]) begin
				t.value  = (tap_addr[i] < 0) ? '0 : image[tap_addr[i]];
				t.padded = (tap_addr[i] < 0);
				t.fault  = 1'b0;
				t.last   = (i == tap_addr.size() - 1);
				due.push_back(t);
			end
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
			errors++;
		endtask

		task check_tap(tap_word_t got);
			tap_word_t want;
			if (due.size() == 0) begin
				report_mismatch("transfer with no tap outstanding", got.value, '0);
				return;
			end
			want = due.pop_front();
			if (got.value !== want.value)
				report_mismatch("value", got.value, want.value);
			if (got.padded !== want.padded)
				report_mismatch("padded", 32'(got.padded), 32'(want.padded));
			if (got.fault !== want.fault)
				report_mismatch("fault", 32'(got.fault), 32'(want.fault));
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = KIND_LOAD;
	logic [ADDR_IN_W-1:0] pixel_address = '0;
	logic [WORD_W-1:0]    pixel_value = '0;
	logic [DIM_W-1:0]     out_row = '0;
	logic [DIM_W-1:0]     out_col = '0;
	logic [CH_W-1:0]      channel_sel = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [WORD_W-1:0]    value;
	logic                 padded;
	logic                 fault;
	logic                 last;

	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;
	bit           hold_req = 1'b0;
	int           ops_sent = 0;
	patch_tracker tracker;

	im2col_patch_gather_core u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			tracker.check_tap('{value: value, padded: padded, fault: fault, last: last});

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_op(pixel_op_t op);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind          <= op.kind;
		pixel_address <= op.addr;
		pixel_value   <= op.word;
		out_row       <= op.row;
		out_col       <= op.col;
		channel_sel   <= op.ch;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.accept_item(op);
		ops_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(int addr, logic [WORD_W-1:0] word);
		send_op('{kind: KIND_LOAD, addr: addr[ADDR_IN_W-1:0], word: word,
			row: DIM_W'($urandom), col: DIM_W'($urandom), ch: CH_W'($urandom)});
	endtask

	task automatic send_gather(int row, int col, int ch);
		send_op('{kind: KIND_GATHER, addr: ADDR_IN_W'($urandom), word: $urandom,
			row: row[DIM_W-1:0], col: col[DIM_W-1:0], ch: ch[CH_W-1:0]});
	endtask

	// Loads every in-image tap not yet written, then gathers the patch.
	task automatic gather_patch(int row, int col, int ch);
		int addrs [$];
		if (tracker.walk_patch(row, col, ch)) begin
			addrs = tracker.tap_addr;
			foreach (addrs[i])
				if (addrs[i] >= 0 && !tracker.loaded[addrs[i]])
					send_load(addrs[i], $urandom);
		end
		send_gather(row, col, ch);
	endtask

	task automatic random_op();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			send_load($urandom_range(DEF_IMAGE_DEPTH - 1), $urandom);
		else if (pick < 30 || !tracker.geometry_ok())
			gather_patch($urandom_range(127), $urandom_range(127), $urandom_range(63));
		else
			gather_patch($urandom_range(tracker.out_rows() - 1),
				$urandom_range(tracker.out_cols() - 1),
				$urandom_range(int'(tracker.regs.nc) - 1));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		cfg_t             c;
		logic [REG_W-1:0] reg_idx [6];
		logic [31:0]      reg_data [6];
		int               phase_end;
		tracker = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: c = '{nc: 64, h: 64, w: 64, k: 8, s: 8, p: 7};
					2: c = '{nc: 1, h: 1, w: 1, k: 1, s: 1, p: 0};
					// kernel wider than the padded image
					3: c = '{nc: 2, h: 1, w: 1, k: 4, s: 1, p: 1};
					// every register but the pad amount out of range
					4: c = '{nc: 0, h: 127, w: 0, k: 15, s: 0, p: 7};
					// channels 16..19 run past the end of the store
					5: c = '{nc: 20, h: 16, w: 16, k: 2, s: 1, p: 1};
					default: begin
						c.nc = DIM_W'($urandom_range(1, 6));
						c.h  = DIM_W'($urandom_range(1, 12));
						c.w  = DIM_W'($urandom_range(1, 12));
						c.k  = KSZ_W'($urandom_range(1, 4));
						c.s  = KSZ_W'($urandom_range(1, 3));
						c.p  = PAD_W'($urandom_range(0, 2));
					end
				endcase
				reg_idx = '{REG_NUM_CHANNELS, REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH,
					REG_KERNEL_SIZE, REG_STRIDE_STEP, REG_PAD_AMOUNT};
				reg_data = '{32'(c.nc), 32'(c.h), 32'(c.w), 32'(c.k), 32'(c.s), 32'(c.p)};
				foreach (reg_idx[r]) begin
					psel    <= 1'b1;
					penable <= 1'b0;
					pwrite  <= 1'b1;
					paddr   <= {reg_idx[r], 2'b00};
					pwdata  <= reg_data[r];
					@(negedge clk);
					penable <= 1'b1;
					do @(posedge clk); while (!pready);
					tracker.set_reg(reg_idx[r], reg_data[r]);
					@(negedge clk);
				end
				psel    <= 1'b0;
				penable <= 1'b0;
				pwrite  <= 1'b0;
			end

			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
				default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
			endcase

			case (ph)
				0: begin
					// 8x8 image, 3x3 kernel, pad 1: corners, interior, range edges
					send_load(0, 32'h0000_0000);
					send_load(1, 32'hFFFF_FFFF);
					send_load(8, 32'hA5A5_A5A5);
					send_load(9, 32'h5A5A_5A5A);
					gather_patch(0, 0, 0);
					send_load(DEF_IMAGE_DEPTH - 1, 32'hFFFF_FFFF);
					send_load(DEF_IMAGE_DEPTH - 1, 32'h0000_0000);
					gather_patch(7, 7, 0);
					gather_patch(3, 4, 0);
					send_gather(8, 0, 0);
					send_gather(0, 8, 0);
					send_gather(127, 127, 0);
					send_gather(0, 0, 1);
					send_gather(0, 0, 63);
				end
				1: begin
					send_gather(0, 0, 1);    // store overrun
					gather_patch(0, 0, 0);   // a single in-image tap
					gather_patch(8, 0, 0);   // bottom edge, mostly padding
					send_gather(9, 0, 0);
					send_gather(0, 9, 0);
				end
				2: begin
					gather_patch(0, 0, 0);
					send_gather(1, 0, 0);
					send_gather(0, 1, 0);
				end
				default: ;
			endcase

			phase_end = ops_sent + ((ph < 3) ? 30 : (ph < 5) ? 15 : 50);
			if (ph == 6)
				hold_req = 1'b1;   // sink holds off while the source keeps offering
			while (ops_sent < phase_end - 25)
				random_op();
			if (ph == 7)
				drain();           // source pauses until every tap is back
			while (ops_sent < phase_end)
				random_op();
		end

		drain();
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
